// ----- src/dpfg_pkg.sv -----
// Shared constants, types and the curve table of the dual ping-pong fade generator.
package dpfg_pkg;

    localparam int FRAC_BITS        = 8;
    localparam int CURVE_INDEX_BITS = 8;

    localparam int LEVEL_W     = 16;
    localparam int STEP_W      = 11;
    localparam int OUT_W       = 8;
    localparam int CURVE_W     = FRAC_BITS + 1;
    localparam int CURVE_DEPTH = 1 << CURVE_INDEX_BITS;
    localparam int STEP_SUM_W  = ((STEP_W > CURVE_W) ? STEP_W : CURVE_W) + 1;
    localparam int MOVE_W      = LEVEL_W + 2;
    localparam int REM_W       = LEVEL_W + 1;
    localparam int DIV_CNT_W   = $clog2(CURVE_INDEX_BITS + 1);

    localparam int NUM_REGS = 6;
    localparam int ADDR_W   = $clog2(NUM_REGS * 4);
    localparam int IDX_W    = ADDR_W - 2;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << FRAC_BITS;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_BRIGHT_FLOOR = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_BRIGHT_CEIL  = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_BRIGHT_BASE  = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_HUE_FLOOR    = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_HUE_CEIL     = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_HUE_STEP     = IDX_W'(5);

    localparam logic [LEVEL_W-1:0] RST_BRIGHT_FLOOR = 16'd12800;
    localparam logic [LEVEL_W-1:0] RST_BRIGHT_CEIL  = 16'd65280;
    localparam logic [STEP_W-1:0]  RST_BRIGHT_BASE  = 11'd128;
    localparam logic [LEVEL_W-1:0] RST_HUE_FLOOR    = 16'd256;
    localparam logic [LEVEL_W-1:0] RST_HUE_CEIL     = 16'd12800;
    localparam logic [STEP_W-1:0]  RST_HUE_STEP     = 11'd128;

    typedef logic [CURVE_W-1:0] t_curve_rom [CURVE_DEPTH];

    // Build 1.6*exp(-10*i/depth) in fixed point with a 30-bit fraction series.
    function automatic t_curve_rom build_curve_rom();
        t_curve_rom        rom;
        longint unsigned   z;
        longint unsigned   pos;
        longint unsigned   neg;
        longint unsigned   term;
        longint unsigned   e;
        longint unsigned   val;
        longint unsigned   half;
        for (int i = 0; i < CURVE_DEPTH; i++) begin
            half = 64'd1 << 29;
            z    = 64'(10 * i) << (26 - CURVE_INDEX_BITS);
            pos  = 64'd1 << 30;
            neg  = 64'd0;
            term = 64'd1 << 30;
            for (int k = 1; k <= 14; k++) begin
                term = ((term * z) >> 30) / 64'(k);
                if ((k % 2) == 1) begin
                    neg = neg + term;
                end else begin
                    pos = pos + term;
                end
            end
            e = (pos > neg) ? (pos - neg) : 64'd0;
            for (int k = 0; k < 4; k++) begin
                e = (e * e + half) >> 30;
            end
            val    = (((e << (FRAC_BITS + 3)) / 64'd5) + half) >> 30;
            rom[i] = CURVE_W'(val);
        end
        return rom;
    endfunction

    localparam t_curve_rom CURVE_ROM = build_curve_rom();

    // Integer part of a level, saturated to the output width.
    function automatic logic [OUT_W-1:0] int_part(input logic [LEVEL_W-1:0] level);
        logic [LEVEL_W-1:0] v;
        v = level >> FRAC_BITS;
        return (v > LEVEL_W'(255)) ? OUT_W'(255) : v[OUT_W-1:0];
    endfunction

endpackage

// ----- src/dual_pingpong_fade_generator_core.sv -----
// Top level of the dual ping-pong fade generator: config port, sequencer and ramp unit.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+------------------------------------------
//  s_      | in        | s_tvalid / s_tready       | s_tdata[0] frame_tick, [7:1] zero
//  m_      | out       | m_tvalid / m_tready       | m_tdata bright_out, hue_out, dirs
//  apb     | in/out    | psel, penable, pwrite     | paddr 4*i, pwdata/prdata 32 bits
//
//  frame_tick = 1: from acceptance to the result register come prep, divider load,
//  one divider step per bit of CURVE_INDEX_BITS, done flag, step lookup, two moves
//  on the shared move unit and the output load; the idle state follows.
//  frame_tick = 0: straight to the done step and the output load. s_tready is high
//  only while idle; the next request is taken while a result waits, and the done
//  step holds until the output register frees. Reset: synchronous, active low, not payload regs.
module dual_pingpong_fade_generator_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,    // [0] frame_tick, [7:1] zero
    // output stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [23:0]                  m_tdata,    // [7:0] bright_out, [15:8] hue_out,
                                                     // [16] bright_rising, [17] hue_rising
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dpfg_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_LOAD   = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_STEP   = 3'd4;
    localparam logic [2:0] S_MOVE_B = 3'd5;
    localparam logic [2:0] S_MOVE_H = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    localparam int LW = dpfg_pkg::LEVEL_W;
    localparam int SW = dpfg_pkg::STEP_W;

    // configuration registers
    logic [LW-1:0] r_bright_floor, r_bright_ceil, r_hue_floor, r_hue_ceil;
    logic [SW-1:0] r_bright_base, r_hue_step;

    // ramp state
    logic [LW-1:0] r_bright_level, r_hue_level;
    logic          r_bright_up, r_hue_up;

    // working registers
    logic [2:0]                       r_state, n_state;
    logic [LW-1:0]                    r_blo, r_bhi, r_hlo, r_hhi;
    logic [dpfg_pkg::STEP_SUM_W-1:0]  r_bstep;

    logic        r_m_tvalid;
    logic [23:0] r_m_tdata;

    logic [dpfg_pkg::IDX_W-1:0] reg_idx;
    logic                       cfg_wr;
    logic                       s_fire;
    logic                       div_start;
    logic                       div_done;
    logic [dpfg_pkg::CURVE_INDEX_BITS-1:0] div_index;
    logic                       out_free;

    // shared move unit
    logic [LW-1:0]                   mv_level, mv_lo, mv_hi;
    logic [dpfg_pkg::STEP_SUM_W-1:0] mv_step;
    logic                            mv_up;
    logic signed [dpfg_pkg::MOVE_W-1:0] mv_sum;
    logic [LW-1:0]                   mv_level_new;
    logic                            mv_up_new;

    assign pready   = 1'b1;
    assign reg_idx  = paddr[dpfg_pkg::ADDR_W-1:2];
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign s_tready = (r_state == S_IDLE);
    assign s_fire   = s_tvalid & s_tready;
    assign out_free = ~r_m_tvalid | m_tready;
    assign div_start = (r_state == S_LOAD);

    // register read-back
    always_comb begin
        case (reg_idx)
            dpfg_pkg::REG_BRIGHT_FLOOR: prdata = 32'(r_bright_floor);
            dpfg_pkg::REG_BRIGHT_CEIL:  prdata = 32'(r_bright_ceil);
            dpfg_pkg::REG_BRIGHT_BASE:  prdata = 32'(r_bright_base);
            dpfg_pkg::REG_HUE_FLOOR:    prdata = 32'(r_hue_floor);
            dpfg_pkg::REG_HUE_CEIL:     prdata = 32'(r_hue_ceil);
            dpfg_pkg::REG_HUE_STEP:     prdata = 32'(r_hue_step);
            default:                    prdata = 32'd0;
        endcase
    end

    // register writes; unknown indexes drop the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright_floor <= dpfg_pkg::RST_BRIGHT_FLOOR;
            r_bright_ceil  <= dpfg_pkg::RST_BRIGHT_CEIL;
            r_bright_base  <= dpfg_pkg::RST_BRIGHT_BASE;
            r_hue_floor    <= dpfg_pkg::RST_HUE_FLOOR;
            r_hue_ceil     <= dpfg_pkg::RST_HUE_CEIL;
            r_hue_step     <= dpfg_pkg::RST_HUE_STEP;
        end else if (cfg_wr) begin
            case (reg_idx)
                dpfg_pkg::REG_BRIGHT_FLOOR: r_bright_floor <= pwdata[LW-1:0];
                dpfg_pkg::REG_BRIGHT_CEIL:  r_bright_ceil  <= pwdata[LW-1:0];
                dpfg_pkg::REG_BRIGHT_BASE:  r_bright_base  <= pwdata[SW-1:0];
                dpfg_pkg::REG_HUE_FLOOR:    r_hue_floor    <= pwdata[LW-1:0];
                dpfg_pkg::REG_HUE_CEIL:     r_hue_ceil     <= pwdata[LW-1:0];
                dpfg_pkg::REG_HUE_STEP:     r_hue_step     <= pwdata[SW-1:0];
                default: ;
            endcase
        end
    end

    // curve index divider, shared by nothing else but kept behind its own boundary
    dpfg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_level (r_bright_level),
        .i_ceil  (r_bhi),
        .o_done  (div_done),
        .o_index (div_index)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_state = s_tdata[0] ? S_PREP : S_DONE;
                end
            end
            S_PREP:   n_state = S_LOAD;
            S_LOAD:   n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_STEP;
                end
            end
            S_STEP:   n_state = S_MOVE_B;
            S_MOVE_B: n_state = S_MOVE_H;
            S_MOVE_H: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // operand select for the move unit: brightness first, then hue
    always_comb begin
        if (r_state == S_MOVE_H) begin
            mv_level = r_hue_level;
            mv_up    = r_hue_up;
            mv_lo    = r_hlo;
            mv_hi    = r_hhi;
            mv_step  = dpfg_pkg::STEP_SUM_W'(r_hue_step);
        end else begin
            mv_level = r_bright_level;
            mv_up    = r_bright_up;
            mv_lo    = r_blo;
            mv_hi    = r_bhi;
            mv_step  = r_bstep;
        end
    end

    // advance, clamp at the ceiling, then clamp at the floor
    always_comb begin
        if (mv_up) begin
            mv_sum = $signed(dpfg_pkg::MOVE_W'(mv_level)) + $signed(dpfg_pkg::MOVE_W'(mv_step));
        end else begin
            mv_sum = $signed(dpfg_pkg::MOVE_W'(mv_level)) - $signed(dpfg_pkg::MOVE_W'(mv_step));
        end
        mv_level_new = mv_sum[LW-1:0];
        mv_up_new    = mv_up;
        if (mv_sum >= $signed(dpfg_pkg::MOVE_W'(mv_hi))) begin
            mv_level_new = mv_hi;
            mv_up_new    = 1'b0;
        end
        if (($signed(dpfg_pkg::MOVE_W'(mv_level_new)) <= $signed(dpfg_pkg::MOVE_W'(mv_lo)))
            || (mv_sum <= $signed(dpfg_pkg::MOVE_W'(mv_lo)))) begin
            mv_level_new = mv_lo;
            mv_up_new    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_bright_level <= '0;
            r_bright_up    <= 1'b1;
            r_hue_level    <= '0;
            r_hue_up       <= 1'b1;
            r_m_tvalid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_MOVE_B) begin
                r_bright_level <= mv_level_new;
                r_bright_up    <= mv_up_new;
            end
            if (r_state == S_MOVE_H) begin
                r_hue_level <= mv_level_new;
                r_hue_up    <= mv_up_new;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_m_tvalid <= 1'b1;
            end else if (m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_PREP) begin
            // put swapped bounds in order, floor each ceiling at 1.0
            if (r_bright_floor > r_bright_ceil) begin
                r_blo <= r_bright_ceil;
                r_bhi <= (r_bright_floor < dpfg_pkg::LEVEL_ONE) ?
                         dpfg_pkg::LEVEL_ONE : r_bright_floor;
            end else begin
                r_blo <= r_bright_floor;
                r_bhi <= (r_bright_ceil < dpfg_pkg::LEVEL_ONE) ?
                         dpfg_pkg::LEVEL_ONE : r_bright_ceil;
            end
            if (r_hue_floor > r_hue_ceil) begin
                r_hlo <= r_hue_ceil;
                r_hhi <= (r_hue_floor < dpfg_pkg::LEVEL_ONE) ?
                         dpfg_pkg::LEVEL_ONE : r_hue_floor;
            end else begin
                r_hlo <= r_hue_floor;
                r_hhi <= (r_hue_ceil < dpfg_pkg::LEVEL_ONE) ?
                         dpfg_pkg::LEVEL_ONE : r_hue_ceil;
            end
        end
        if (r_state == S_STEP) begin
            r_bstep <= dpfg_pkg::STEP_SUM_W'(r_bright_base)
                     + dpfg_pkg::STEP_SUM_W'(dpfg_pkg::CURVE_ROM[div_index]);
        end
        if ((r_state == S_DONE) && out_free) begin
            r_m_tdata <= {6'd0, r_hue_up, r_bright_up,
                          dpfg_pkg::int_part(r_hue_level),
                          dpfg_pkg::int_part(r_bright_level)};
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;

endmodule

// ----- src/dpfg_div.sv -----
// Serial restoring divider giving the saturated curve index floor(level*2^n/ceiling).
module dpfg_div (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_start,
    input  logic [dpfg_pkg::LEVEL_W-1:0]              i_level,
    input  logic [dpfg_pkg::LEVEL_W-1:0]              i_ceil,
    output logic                                      o_done,
    output logic [dpfg_pkg::CURVE_INDEX_BITS-1:0]     o_index
);

    logic [dpfg_pkg::REM_W-1:0]            r_rem;
    logic [dpfg_pkg::CURVE_INDEX_BITS-1:0] r_quo;
    logic [dpfg_pkg::DIV_CNT_W-1:0]        r_cnt;
    logic                                  r_sat;
    logic                                  r_done;

    logic [dpfg_pkg::REM_W-1:0] shifted;
    logic                       fits;

    assign shifted = {r_rem[dpfg_pkg::REM_W-2:0], 1'b0};
    assign fits    = (shifted >= {1'b0, i_ceil});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= dpfg_pkg::DIV_CNT_W'(dpfg_pkg::CURVE_INDEX_BITS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == dpfg_pkg::DIV_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_level};
            r_quo <= '0;
            r_sat <= (i_level >= i_ceil);
        end else if (r_cnt != '0) begin
            // one quotient bit per cycle
            r_rem <= fits ? (shifted - {1'b0, i_ceil}) : shifted;
            r_quo <= {r_quo[dpfg_pkg::CURVE_INDEX_BITS-2:0], fits};
        end
    end

    assign o_done  = r_done;
    assign o_index = r_sat ? '1 : r_quo;

endmodule

// ----- src/dpfg_chk.sv -----
// Port-level checker for the fade generator core and its bind.
module dpfg_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [7:0]                   s_tdata,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [23:0]                  m_tdata,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [dpfg_pkg::ADDR_W-1:0]  paddr,
    input logic [31:0]                  pwdata,
    input logic [31:0]                  prdata,
    input logic                         pready
);

    // one request at a time: busy right after a request is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("core ready again right after taking a request");

    // a held result keeps its value
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or dropped");

    // reset leaves the core idle with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_tvalid && s_tready))
        else $error("core not idle after reset");

    // pad bits of the result stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[23:18] == 6'd0))
        else $error("result pad bits set");

endmodule

bind dual_pingpong_fade_generator_core dpfg_chk u_dpfg_chk (.*);
